// ===== src/olist_pkg.sv =====
`default_nettype none

package olist_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LEN_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_DELETE    = 3'd2,
    KIND_READ      = 3'd3,
    KIND_CLEAR     = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_ENTRY     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // What every cell does, set for all cells at once
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_WRITE_TAIL,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                    op;
    logic [LEN_W-1:0]            len;
    logic signed [VALUE_W-1:0]   data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/ordered_list_engine_top.sv =====
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// Commands (kind on s_axis_tuser): insert at front or back, delete the first
// word equal to the key, clear, read out. Read out sends the stored words
// front first, since the list rotates one cell per word through the head
// cell; an empty list answers read out with one word of status empty. Every
// command but a non-empty read out gives exactly one result word, with tlast
// set on the final word of each command.
// A new command is taken once the previous one has placed all its result words
// in the output register and that register is empty or being drained.
module ordered_list_engine_top (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [31:0]                          s_axis_tdata,  // [31:0] value
  input  wire  [2:0]                           s_axis_tuser,  // [2:0] kind
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [39:0]                          m_axis_tdata,  // [31:0] entry_value,
                                                              // [38:32] entry_count
  output logic [2:0]                           m_axis_tuser,  // [2:0] status
  output logic                                 m_axis_tlast
);
  import olist_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e                    state_q, state_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic [IDX_W-1:0]          cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;
  status_e                   status_q, status_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic [COUNT_W-1:0]        count_q, count_d;
  logic                      last_q, last_d;

  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  logic                      hit_chain  [CAPACITY+1];
  logic                      out_free;
  logic                      accept;
  logic                      full;
  logic                      found;
  logic                      read_last;
  kind_e                     kind;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign kind      = kind_e'(s_axis_tuser);
  assign full      = len_q == LEN_W'(CAPACITY);
  assign found     = hit_chain[CAPACITY];
  assign read_last = LEN_W'(cnt_q) == LEN_W'(len_q - 1'b1);
  assign hit_chain[0] = 1'b0;

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_w;
      logic signed [VALUE_W-1:0] right_w;
      if (g == 0) begin : g_head
        assign left_w = s_axis_tdata;
      end else begin : g_mid
        assign left_w = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_end
        assign right_w = cell_value[g];
      end else begin : g_inner
        assign right_w = cell_value[g+1];
      end
      olist_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl),
        .idx_i   (IDX_W'(g)),
        .left_i  (left_w),
        .right_i (right_w),
        .head_i  (cell_value[0]),
        .hit_i   (hit_chain[g]),
        .hit_o   (hit_chain[g+1]),
        .value_o (cell_value[g])
      );
    end
  endgenerate

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    status_d    = status_q;
    value_d     = value_q;
    count_d     = count_q;
    last_d      = last_q;
    ctrl.op     = CELL_HOLD;
    ctrl.len    = len_q;
    ctrl.data   = s_axis_tdata;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          status_d    = ST_DONE;
          value_d     = '0;
          last_d      = 1'b1;
          case (kind)
            KIND_INS_FRONT: begin
              if (full) status_d = ST_FULL;
              else begin
                ctrl.op = CELL_SHIFT_IN;
                len_d   = len_q + 1'b1;
              end
            end
            KIND_INS_BACK: begin
              if (full) status_d = ST_FULL;
              else begin
                ctrl.op = CELL_WRITE_TAIL;
                len_d   = len_q + 1'b1;
              end
            end
            KIND_DELETE: begin
              // cells close the gap themselves when the key is present
              ctrl.op = CELL_DELETE;
              if (found) len_d = len_q - 1'b1;
              else status_d = ST_NOT_FOUND;
            end
            KIND_READ: begin
              if (len_q == '0) status_d = ST_EMPTY;
              else begin
                out_valid_d = 1'b0;
                state_d     = S_READ;
                cnt_d       = '0;
              end
            end
            KIND_CLEAR: len_d = '0;
            default: status_d = ST_DONE;
          endcase
          count_d = COUNT_W'(len_d);
        end
      end
      S_READ: begin
        if (out_free) begin
          ctrl.op     = CELL_ROTATE;
          out_valid_d = 1'b1;
          status_d    = ST_ENTRY;
          value_d     = cell_value[0];
          count_d     = COUNT_W'(len_q);
          last_d      = read_last;
          cnt_d       = cnt_q + 1'b1;
          if (read_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
      value_q     <= '0;
      count_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      value_q     <= value_d;
      count_q     <= count_d;
      last_q      <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, count_q, value_q};
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = last_q;

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> len_q != '0)
    else $error("read out running on an empty list");

  a_read_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> !s_axis_tready)
    else $error("command taken during read out");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser == KIND_CLEAR |=> len_q == '0 && m_axis_tvalid)
    else $error("clear left entries behind");

  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser == KIND_READ && len_q == '0
      |=> m_axis_tvalid && m_axis_tuser == ST_EMPTY && m_axis_tlast)
    else $error("empty read out gave no empty word");
`endif

endmodule

`default_nettype wire

// ===== src/olist_cell.sv =====
`default_nettype none

module olist_cell (
  input  wire                                  clk_i,
  input  wire  olist_pkg::cell_ctrl_t          ctrl_i,
  input  wire  [olist_pkg::IDX_W-1:0]          idx_i,
  input  wire  signed [olist_pkg::VALUE_W-1:0] left_i,
  input  wire  signed [olist_pkg::VALUE_W-1:0] right_i,
  input  wire  signed [olist_pkg::VALUE_W-1:0] head_i,
  input  wire                                  hit_i,
  output logic                                 hit_o,
  output logic signed [olist_pkg::VALUE_W-1:0] value_o
);
  import olist_pkg::*;

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic [LEN_W-1:0]          pos;
  logic [LEN_W-1:0]          tail_pos;
  logic                      in_list;

  assign pos      = LEN_W'(idx_i);
  assign tail_pos = LEN_W'(ctrl_i.len - 1'b1);
  assign in_list  = pos < ctrl_i.len;
  // a match here or anywhere in front of this cell
  assign hit_o    = hit_i | (in_list && (value_q == ctrl_i.data));
  assign value_o  = value_q;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      CELL_SHIFT_IN:   value_d = left_i;
      CELL_WRITE_TAIL: if (pos == ctrl_i.len) value_d = ctrl_i.data;
      CELL_DELETE:     if (hit_o) value_d = right_i;
      CELL_ROTATE: begin
        // tail takes the head word, the rest of the list moves one step forward
        if (pos == tail_pos) value_d = head_i;
        else if (in_list) value_d = right_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== tb/ordered_list_engine_top_tb.sv =====
`timescale 1ns / 100ps

module ordered_list_engine_top_tb;
  import olist_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 440;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned TAIL_CYCLES  = 20;

  // Kind codes the block does not define; they must answer done
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  entry_value;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;
  } list_word_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic signed [VALUE_W-1:0] list_shadow[$];
  list_word_t                expected_words[$];
  list_word_t                seen_word;
  list_word_t                want_word;

  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 70;
  int unsigned commands_sent = 0;
  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;

  ordered_list_engine_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic expect_word(input logic [STATUS_W-1:0] status,
                             input logic [VALUE_W-1:0] entry_value, input logic last);
    list_word_t w;
    w.status      = status;
    w.entry_value = entry_value;
    w.entry_count = COUNT_W'(list_shadow.size());
    w.last        = last;
    expected_words.push_back(w);
  endtask

  // Apply one command to the shadow list and queue the words it must produce
  task automatic apply_list_command(input logic [2:0] kind,
                                    input logic signed [VALUE_W-1:0] value);
    int hit;
    hit = -1;
    case (kind)
      KIND_INS_FRONT, KIND_INS_BACK: begin
        if (list_shadow.size() >= CAPACITY) begin
          expect_word(ST_FULL, '0, 1'b1);
        end else begin
          if (kind == KIND_INS_FRONT) list_shadow.push_front(value);
          else list_shadow.push_back(value);
          expect_word(ST_DONE, '0, 1'b1);
        end
      end
      KIND_DELETE: begin
        for (int i = 0; i < list_shadow.size(); i++) begin
          if (hit < 0 && list_shadow[i] == value) hit = i;
        end
        if (hit < 0) begin
          expect_word(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          list_shadow.delete(hit);
          expect_word(ST_DONE, '0, 1'b1);
        end
      end
      KIND_READ: begin
        if (list_shadow.size() == 0) expect_word(ST_EMPTY, '0, 1'b1);
        for (int i = 0; i < list_shadow.size(); i++) begin
          expect_word(ST_ENTRY, list_shadow[i], i == list_shadow.size() - 1);
        end
      end
      KIND_CLEAR: begin
        list_shadow.delete();
        expect_word(ST_DONE, '0, 1'b1);
      end
      default: expect_word(ST_DONE, '0, 1'b1);
    endcase
  endtask

  task automatic send_command(input logic [2:0] kind, input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_list_command(kind, value);
    commands_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0, 1:    return 32'(int'($urandom_range(6)) - 3);
      2:       return $urandom;
      default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
    endcase
  endfunction

  // Mostly keys that are present, so deletes reach past the search
  function automatic logic [31:0] pick_key();
    if (list_shadow.size() != 0 && $urandom_range(99) < 75)
      return list_shadow[$urandom_range(list_shadow.size() - 1)];
    return pick_value();
  endfunction

  task automatic test_empty_list();
    send_command(KIND_READ, 32'hffff_ffff);
    send_command(KIND_DELETE, 32'h0000_0000);
  endtask

  task automatic test_insert_extremes();
    send_command(KIND_INS_FRONT, 32'h8000_0000);
    send_command(KIND_INS_BACK, 32'h7fff_ffff);
    send_command(KIND_INS_FRONT, 32'h0000_0000);
    send_command(KIND_INS_BACK, 32'hffff_ffff);
    send_command(KIND_INS_BACK, 32'h8000_0000);
    send_command(KIND_READ, 32'h5555_aaaa);
  endtask

  task automatic test_delete_cases();
    // duplicate key: only the copy nearest the front goes
    send_command(KIND_DELETE, 32'h8000_0000);
    send_command(KIND_DELETE, 32'h1234_5678);
    send_command(KIND_DELETE, 32'hffff_ffff);
    send_command(KIND_READ, 32'h0);
  endtask

  task automatic test_unknown_kinds();
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) send_command(3'(k), $urandom);
  endtask

  task automatic test_clear();
    send_command(KIND_CLEAR, 32'hdead_beef);
    send_command(KIND_READ, 32'h0);
    send_command(KIND_CLEAR, 32'h0);
  endtask

  task automatic run_list_session();
    int unsigned fill;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 4)) send_command(3'($urandom_range(7)), $urandom);
    end else begin
      if ($urandom_range(1)) send_command(KIND_CLEAR, $urandom);
      fill = $urandom_range(1, CAPACITY + 3);
      repeat (fill) send_command($urandom_range(1) ? KIND_INS_FRONT : KIND_INS_BACK, pick_value());
      send_command(KIND_READ, $urandom);
      repeat ($urandom_range(4)) send_command(KIND_DELETE, pick_key());
      send_command(KIND_READ, $urandom);
    end
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned item_total);
    int unsigned stop_at;
    int unsigned pause_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at  = commands_sent + item_total;
    pause_at = commands_sent + item_total / 2;
    while (commands_sent < stop_at) begin
      run_list_session();
      if (pause_at != 0 && commands_sent >= pause_at) begin
        wait_drained();
        pause_at = 0;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_word.status      = m_axis_tuser;
      seen_word.entry_value = m_axis_tdata[31:0];
      seen_word.entry_count = m_axis_tdata[38:32];
      seen_word.last        = m_axis_tlast;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, got status %0d value %0d count %0d last %0b",
                 $time, seen_word.status, $signed(seen_word.entry_value),
                 seen_word.entry_count, seen_word.last);
        error_count++;
      end else begin
        want_word = expected_words.pop_front();
        if (seen_word.status !== want_word.status ||
            seen_word.entry_value !== want_word.entry_value ||
            seen_word.entry_count !== want_word.entry_count ||
            seen_word.last !== want_word.last) begin
          $display("%0t: expected status %0d value %0d count %0d last %0b",
                   $time, want_word.status, $signed(want_word.entry_value),
                   want_word.entry_count, want_word.last);
          $display("%0t:   actual status %0d value %0d count %0d last %0b",
                   $time, seen_word.status, $signed(seen_word.entry_value),
                   seen_word.entry_count, seen_word.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_insert_extremes();
    test_delete_cases();
    test_unknown_kinds();
    test_clear();

    test_random_traffic(24, 70, RANDOM_ITEMS / 3);
    test_random_traffic(70, 24, RANDOM_ITEMS / 3);
    test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
